FILE: hdl/sctm_pkg.sv
package sctm_pkg;

   localparam int DEFAULT_CAPTURE_DEPTH = 320;

   localparam int SAMPLE_W = 12;
   localparam int COLUMN_W = 9;
   localparam int VSCALE_W = 6;
   localparam int TSCALE_W = 5;
   localparam int ROW_W    = 8;
   localparam int TRIG_W   = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [SAMPLE_W-1:0] MID_SCALE  = 12'd2048;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
   localparam logic [ROW_W-1:0]    ROW_CENTER = 8'd120;
   localparam logic [ROW_W-1:0]    ROW_MIN    = 8'd2;
   localparam logic [ROW_W-1:0]    ROW_MAX    = 8'd237;

   localparam logic [VSCALE_W-1:0] VSCALE_RESET = 6'd5;
   localparam logic [TSCALE_W-1:0] TSCALE_RESET = 5'd1;

   // divide by 85 as multiply by rounded-up reciprocal, exact for 17-bit magnitudes
   localparam int GAIN_DIVISOR = 85;
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP_W      = 18;
   localparam logic [RECIP_W-1:0] GAIN_RECIP =
      RECIP_W'((2**RECIP_SHIFT + GAIN_DIVISOR - 1) / GAIN_DIVISOR);

   localparam int PROD_W = 20;   // signed (sample - mid) * vscale
   localparam int MAG_W  = 17;
   localparam int QUOT_W = 11;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_READ = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VSCALE = 1'b0,
      CSR_TSCALE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_MOD,
      ST_MEM,
      ST_SCALE,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic mul;
      logic mod_step;
      logic mem_rd;
      logic scale;
      logic div;
      logic out_write;
   } cmd_type;

   typedef struct packed {
      logic mod_last;
      logic rsp_busy;
   } status_type;

endpackage

FILE: hdl/sctm_dp.sv
module sctm_dp
   import sctm_pkg::*;
#(
   parameter int CAPTURE_DEPTH = DEFAULT_CAPTURE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  req_func,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic [COLUMN_W-1:0]   req_column,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [ROW_W-1:0]      rsp_row,
   output logic [TRIG_W-1:0]     rsp_trigger_at,
   output logic [SAMPLE_W-1:0]   rsp_peak_high,
   output logic [SAMPLE_W-1:0]   rsp_peak_low,
   output logic                  rsp_frame_done
);

   localparam int AW     = $clog2(CAPTURE_DEPTH);
   localparam int IW     = $clog2(CAPTURE_DEPTH + 1);
   localparam int TW     = $clog2(CAPTURE_DEPTH / 2);
   localparam int MW     = COLUMN_W + TSCALE_W;
   localparam int SUM_W  = ((MW > TW) ? MW : TW) + 1;
   localparam int QW     = SUM_W - AW + 1;
   // modulo by the depth as multiply by rounded-up reciprocal, exact for SUM_W-bit sums
   localparam int MOD_SHIFT = SUM_W + AW;
   localparam int MOD_RW    = SUM_W + 1;
   localparam int MP_W      = SUM_W + MOD_RW;
   localparam logic [MOD_RW-1:0] MOD_RECIP =
      MOD_RW'((2**MOD_SHIFT + CAPTURE_DEPTH - 1) / CAPTURE_DEPTH);

   logic [SAMPLE_W-1:0] store [CAPTURE_DEPTH];

   logic                func_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [COLUMN_W-1:0] column_ff;
   logic [VSCALE_W-1:0] vscale_ff;
   logic [TSCALE_W-1:0] tscale_ff;

   logic [IW-1:0]       widx_ff, widx_in;
   logic [SAMPLE_W-1:0] prev_ff;
   logic [TW-1:0]       trig_ff, trig_in;
   logic                found_ff, found_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic                done_ff, done_in;

   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [QW-1:0]       mq_ff, mq_in;
   logic                cnt_ff;
   logic [SAMPLE_W-1:0] rd_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic                neg_ff;

   logic [ROW_W-1:0]    row_ff;
   logic [TRIG_W-1:0]   trig_at_ff;
   logic [SAMPLE_W-1:0] high_ff, low_ff;
   logic                fdone_ff;

   // frame bookkeeping for a load, with a new frame started after a full one
   logic [IW-1:0]       cur_idx;
   logic [TW-1:0]       cur_trig;
   logic                cur_found;
   logic [SAMPLE_W-1:0] cur_max, cur_min;
   logic                hit;

   always_comb begin
      cur_idx   = done_ff ? '0 : widx_ff;
      cur_trig  = done_ff ? '0 : trig_ff;
      cur_found = done_ff ? 1'b0 : found_ff;
      cur_max   = done_ff ? '0 : max_ff;
      cur_min   = done_ff ? FULL_SCALE : min_ff;
      hit = !cur_found && (cur_idx != '0) && (cur_idx < IW'(CAPTURE_DEPTH / 2)) &&
            (prev_ff < MID_SCALE) && (sample_ff >= MID_SCALE);
      widx_in  = cur_idx + IW'(1);
      done_in  = (cur_idx == IW'(CAPTURE_DEPTH - 1));
      max_in   = (sample_ff > cur_max) ? sample_ff : cur_max;
      min_in   = (sample_ff < cur_min) ? sample_ff : cur_min;
      found_in = cur_found | hit;
      trig_in  = hit ? cur_idx[TW-1:0] : cur_trig;
   end

   // read address: reciprocal multiply for the quotient, then subtract it out
   logic [SUM_W-1:0] sum_val;
   logic [MP_W-1:0]  mod_prod;
   assign sum_val  = SUM_W'(column_ff) * SUM_W'(tscale_ff) + SUM_W'(trig_ff);
   assign mod_prod = MP_W'(rem_ff) * MP_W'(MOD_RECIP);
   assign mq_in    = mod_prod[MOD_SHIFT +: QW];
   assign rem_in   = rem_ff - SUM_W'(mq_ff) * SUM_W'(CAPTURE_DEPTH);

   // gain stage
   logic signed [SAMPLE_W:0] diff;
   logic signed [VSCALE_W:0] vsc;
   assign diff    = $signed({1'b0, rd_ff}) - $signed({1'b0, MID_SCALE});
   assign vsc     = $signed({1'b0, vscale_ff});
   assign prod_in = diff * vsc;

   logic [PROD_W-1:0]          mag_full;
   logic [MAG_W-1:0]           mag;
   logic [MAG_W+RECIP_W-1:0]   recip_prod;
   assign mag_full   = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign mag        = mag_full[MAG_W-1:0];
   assign recip_prod = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(GAIN_RECIP);
   assign quot_in    = recip_prod[RECIP_SHIFT +: QUOT_W];

   // row = 120 - signed quotient, clamped
   logic [ROW_W-1:0] row_calc;
   always_comb begin
      if (neg_ff) begin
         if (quot_ff > QUOT_W'(ROW_MAX - ROW_CENTER)) row_calc = ROW_MAX;
         else row_calc = ROW_CENTER + quot_ff[ROW_W-1:0];
      end else begin
         if (quot_ff > QUOT_W'(ROW_CENTER - ROW_MIN)) row_calc = ROW_MIN;
         else row_calc = ROW_CENTER - quot_ff[ROW_W-1:0];
      end
   end

   logic [TW+TRIG_W-1:0] trig_ext;
   assign trig_ext = (TW+TRIG_W)'(trig_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vscale_ff <= VSCALE_RESET;
         tscale_ff <= TSCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_VSCALE: vscale_ff <= csr_wdata[VSCALE_W-1:0];
            CSR_TSCALE: tscale_ff <= csr_wdata[TSCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff  <= '0;
         prev_ff  <= '0;
         trig_ff  <= '0;
         found_ff <= 1'b0;
         max_ff   <= '0;
         min_ff   <= FULL_SCALE;
         done_ff  <= 1'b0;
      end else if (cmd.load) begin
         widx_ff  <= widx_in;
         prev_ff  <= sample_ff;
         trig_ff  <= trig_in;
         found_ff <= found_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) store[cur_idx[AW-1:0]] <= sample_ff;
      if (cmd.mem_rd) rd_ff <= store[rem_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         sample_ff <= req_sample;
         column_ff <= req_column;
      end
      // first modulo step takes the quotient, the second the remainder
      if (cmd.mul) begin
         rem_ff <= sum_val;
         cnt_ff <= 1'b1;
      end else if (cmd.mod_step) begin
         if (cnt_ff) mq_ff <= mq_in;
         else rem_ff <= rem_in;
         cnt_ff <= 1'b0;
      end
      if (cmd.scale) prod_ff <= prod_in;
      if (cmd.div) begin
         quot_ff <= quot_in;
         neg_ff  <= prod_ff[PROD_W-1];
      end
      if (cmd.out_write) begin
         row_ff     <= (func_ff == FUNC_READ) ? row_calc : ROW_MIN;
         trig_at_ff <= trig_ext[TRIG_W-1:0];
         high_ff    <= max_ff;
         low_ff     <= min_ff;
         fdone_ff   <= done_ff;
      end
   end

   assign status.mod_last = !cnt_ff;
   assign status.rsp_busy = rsp_valid & rsp_stall;

   assign rsp_row        = row_ff;
   assign rsp_trigger_at = trig_at_ff;
   assign rsp_peak_high  = high_ff;
   assign rsp_peak_low   = low_ff;
   assign rsp_frame_done = fdone_ff;

`ifndef NO_ASSERTIONS
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |-> (rem_ff < SUM_W'(CAPTURE_DEPTH)))
      else $error("read address not reduced below capture depth");

   a_trig_window: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (trig_ff != '0 && IW'(trig_ff) < IW'(CAPTURE_DEPTH / 2)))
      else $error("trigger index outside search window");

   a_done_full: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (widx_ff == IW'(CAPTURE_DEPTH)))
      else $error("frame marked done before store is full");
`endif

endmodule

FILE: hdl/sctm_ctrl.sv
module sctm_ctrl
   import sctm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_func,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = (req_func == FUNC_READ) ? ST_MUL : ST_LOAD;
         ST_LOAD:  state_in = ST_OUT;
         ST_MUL:   state_in = ST_MOD;
         ST_MOD:   if (status.mod_last) state_in = ST_MEM;
         ST_MEM:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DIV;
         ST_DIV:   state_in = ST_OUT;
         ST_OUT:   if (!status.rsp_busy) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:  cmd.capture   = accept;
         ST_LOAD:  cmd.load      = 1'b1;
         ST_MUL:   cmd.mul       = 1'b1;
         ST_MOD:   cmd.mod_step  = 1'b1;
         ST_MEM:   cmd.mem_rd    = 1'b1;
         ST_SCALE: cmd.scale     = 1'b1;
         ST_DIV:   cmd.div       = 1'b1;
         ST_OUT:   cmd.out_write = !status.rsp_busy;
         default:  cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.out_write | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_LOAD || state_ff == ST_MUL))
      else $error("accepted item not dispatched");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while held");

   a_mod_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD && !status.mod_last) |=> (state_ff == ST_MOD))
      else $error("modulo unit left early");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");
`endif

endmodule

FILE: hdl/scope_capture_trigger_mapper.sv
// load item: accept, store the sample and update frame stats, then register the result
// read item: accept, address product, reciprocal modulo (quotient, then remainder),
//   memory read, gain and divide, then register the result; no new item until back in idle
// a stalled result holds the next item in the output state until the result is taken
// synchronous active-high reset clears control, frame stats and scale registers; the sample
//   memory is not cleared and reads of unwritten entries are undefined
module scope_capture_trigger_mapper
   import sctm_pkg::*;
#(
   parameter int CAPTURE_DEPTH = DEFAULT_CAPTURE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic [COLUMN_W-1:0]   req_column,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ROW_W-1:0]      rsp_row,
   output logic [TRIG_W-1:0]     rsp_trigger_at,
   output logic [SAMPLE_W-1:0]   rsp_peak_high,
   output logic [SAMPLE_W-1:0]   rsp_peak_low,
   output logic                  rsp_frame_done,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   sctm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sctm_dp #(
      .CAPTURE_DEPTH (CAPTURE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .req_func       (req_func),
      .req_sample     (req_sample),
      .req_column     (req_column),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_row        (rsp_row),
      .rsp_trigger_at (rsp_trigger_at),
      .rsp_peak_high  (rsp_peak_high),
      .rsp_peak_low   (rsp_peak_low),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule
